>>> rtl/cfa_pkg.sv
// Shared types and constants for the contiguous fit allocator.
`timescale 1ns / 1ps
package cfa_pkg;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_ZERO     = 3'd1;
	localparam logic [2:0] ST_DUP      = 3'd2;
	localparam logic [2:0] ST_NOFIT    = 3'd3;
	localparam logic [2:0] ST_NOTALLOC = 3'd4;
	localparam logic [2:0] ST_FULL     = 3'd5;

	localparam logic CFG_FIT_POLICY  = 1'b0;
	localparam logic CFG_TOTAL_UNITS = 1'b1;

	localparam logic [1:0] POL_BEST  = 2'd1;
	localparam logic [1:0] POL_WORST = 2'd2;

	localparam int MIN_UNITS = 100;

	typedef struct packed {
		logic [11:0] start;
		logic [12:0] len;
		logic [5:0]  owner;
		logic        is_free;
	} blk_entry_t;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_INIT,
		DP_LOAD,
		DP_SCAN_START,
		DP_SCAN,
		DP_UP_START,
		DP_UP,
		DP_WR_SPLIT,
		DP_WR_USED,
		DP_MERGE_WR,
		DP_DOWN,
		DP_FREE_END,
		DP_PUSH
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [2:0] code;
	} dp_cmd_t;

	typedef struct packed {
		logic is_free_req;
		logic zero_size;
		logic id_bad;
		logic id_active;
		logic scan_done;
		logic up_done;
		logic found;
		logic need_split;
		logic table_full;
		logic out_free;
	} dp_sts_t;

endpackage

>>> rtl/contiguous_fit_allocator.sv
// Top level of the contiguous fit allocator.
`timescale 1ns / 1ps
// Keeps an address-ordered table of up to MAX_BLOCKS blocks in one RAM with a
// single read and a single write port; every request is handled on its own.
// An allocate runs its checks and the table scan and, when the chosen block
// is split, moves the entries behind it one place up and writes the new free
// entry; a free runs the same scan, then merges and closes the gap. Early
// errors skip the scan and answer straight with the result beat. A request
// ends with its result beat and a return to idle before the next is taken.
// After reset and after each total_units write the block rebuilds entry
// zero before it takes a request.
// The result register lets a new request start while the last result beat
// still waits on out_ready.
module contiguous_fit_allocator #(
	parameter int MEM_UNITS  = 4096,
	parameter int MAX_BLOCKS = 64,
	parameter int MAX_PROCS  = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [5:0]  proc_id,
	input  logic [12:0] req_size,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [11:0] alloc_start,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [12:0] cfg_data
);

	cfa_pkg::dp_cmd_t cmd;
	cfa_pkg::dp_sts_t sts;

	cfa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_ready(cfg_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cfa_datapath #(
		.MEM_UNITS (MEM_UNITS),
		.MAX_BLOCKS(MAX_BLOCKS),
		.MAX_PROCS (MAX_PROCS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.req_type   (req_type),
		.proc_id    (proc_id),
		.req_size   (req_size),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.alloc_start(alloc_start)
	);

endmodule

>>> rtl/cfa_ram.sv
// Generic single write port, single read port RAM with registered read.
`timescale 1ns / 1ps
module cfa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/cfa_datapath.sv
// Allocator datapath: block table RAM, scan and shift logic, owner flags, result register.
`timescale 1ns / 1ps
module cfa_datapath #(
	parameter int MEM_UNITS  = 4096,
	parameter int MAX_BLOCKS = 64,
	parameter int MAX_PROCS  = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfa_pkg::dp_cmd_t  cmd,
	output cfa_pkg::dp_sts_t  sts,
	input  logic              req_type,
	input  logic [5:0]        proc_id,
	input  logic [12:0]       req_size,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [12:0]       cfg_data,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [2:0]        status,
	output logic [11:0]       alloc_start
);

	localparam int IW = $clog2(MAX_BLOCKS);
	localparam int CW = IW + 1;

	// control state
	logic [CW-1:0] count_q;
	logic [63:0]   owner_active_q;
	logic [1:0]    fit_policy_q;
	logic [12:0]   total_units_q;
	logic          out_valid_q;
	logic          rd_vld_s1;

	// payload
	logic          type_q;
	logic [5:0]    id_q;
	logic [12:0]   size_q;
	logic [CW-1:0] src_q;
	logic [IW-1:0] idx_s1;
	logic          found_q;
	logic [IW-1:0] pick_idx_q;
	logic [12:0]   pick_len_q;
	logic [11:0]   pick_start_q;
	logic          last_free_q;
	logic [12:0]   last_len_q;
	logic [11:0]   last_start_q;
	logic          prev_free_q;
	logic [12:0]   prev_len_q;
	logic [11:0]   prev_start_q;
	logic          next_free_q;
	logic [12:0]   next_len_q;
	logic [2:0]    status_q;
	logic [11:0]   alloc_start_q;

	cfa_pkg::blk_entry_t rdata;
	cfa_pkg::blk_entry_t wd;
	logic                we;
	logic                re;
	logic [IW-1:0]       wa;
	logic [IW-1:0]       dst;
	logic [1:0]          rm_cnt;
	logic                fits;
	logic                take;
	logic                own_hit;
	logic [12:0]         cfg_units;

	cfa_ram #(
		.WIDTH($bits(cfa_pkg::blk_entry_t)),
		.DEPTH(MAX_BLOCKS)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(wa),
		.wdata(wd),
		.re   (re),
		.raddr(src_q[IW-1:0]),
		.rdata(rdata)
	);

	assign rm_cnt = {1'b0, prev_free_q} + {1'b0, next_free_q};

	assign fits = rdata.is_free && (rdata.len >= size_q);
	always_comb begin
		priority if (!found_q) take = fits;
		else if (fit_policy_q == cfa_pkg::POL_BEST) take = fits && (rdata.len < pick_len_q);
		else if (fit_policy_q == cfa_pkg::POL_WORST) take = fits && (rdata.len > pick_len_q);
		else take = 1'b0;
	end
	assign own_hit = !found_q && !rdata.is_free && (rdata.owner == id_q);

	always_comb begin
		re  = 1'b0;
		we  = 1'b0;
		wa  = idx_s1;
		wd  = rdata;
		dst = src_q[IW-1:0];
		unique case (cmd.op)
			cfa_pkg::DP_INIT: begin
				we = 1'b1;
				wa = '0;
				wd = '{start: 12'd0, len: total_units_q, owner: 6'd0, is_free: 1'b1};
			end
			cfa_pkg::DP_SCAN: begin
				re = src_q < count_q;
			end
			cfa_pkg::DP_UP: begin
				re  = src_q > {1'b0, pick_idx_q};
				we  = rd_vld_s1;
				dst = src_q[IW-1:0] + IW'(1);
			end
			cfa_pkg::DP_DOWN: begin
				re  = src_q < count_q;
				we  = rd_vld_s1;
				dst = src_q[IW-1:0] - IW'(rm_cnt);
			end
			cfa_pkg::DP_WR_SPLIT: begin
				we = 1'b1;
				wa = pick_idx_q + IW'(1);
				wd = '{start: pick_start_q + size_q[11:0], len: pick_len_q - size_q,
					owner: 6'd0, is_free: 1'b1};
			end
			cfa_pkg::DP_WR_USED: begin
				we = 1'b1;
				wa = pick_idx_q;
				wd = '{start: pick_start_q, len: size_q, owner: id_q, is_free: 1'b0};
			end
			cfa_pkg::DP_MERGE_WR: begin
				we = 1'b1;
				wa = prev_free_q ? pick_idx_q - IW'(1) : pick_idx_q;
				wd = '{start: prev_free_q ? prev_start_q : pick_start_q,
					len: (prev_free_q ? prev_len_q : 13'd0) + pick_len_q
						+ (next_free_q ? next_len_q : 13'd0),
					owner: 6'd0, is_free: 1'b1};
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		if (cfg_data < 13'(cfa_pkg::MIN_UNITS)) cfg_units = 13'(cfa_pkg::MIN_UNITS);
		else if (32'(cfg_data) > MEM_UNITS) cfg_units = 13'(MEM_UNITS);
		else cfg_units = cfg_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q        <= CW'(1);
			owner_active_q <= '0;
			fit_policy_q   <= 2'd0;
			total_units_q  <= 13'(cfa_pkg::MIN_UNITS);
			out_valid_q    <= 1'b0;
			rd_vld_s1      <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				if (cfg_index == cfa_pkg::CFG_FIT_POLICY) begin
					fit_policy_q <= cfg_data[1:0];
				end else begin
					total_units_q  <= cfg_units;
					owner_active_q <= '0;
				end
			end
			unique case (cmd.op)
				cfa_pkg::DP_INIT: count_q <= CW'(1);
				cfa_pkg::DP_SCAN_START: begin
					rd_vld_s1 <= 1'b0;
					if (type_q) begin
						owner_active_q[id_q] <= 1'b0;
					end
				end
				cfa_pkg::DP_SCAN, cfa_pkg::DP_UP, cfa_pkg::DP_DOWN: rd_vld_s1 <= re;
				cfa_pkg::DP_UP_START, cfa_pkg::DP_MERGE_WR: rd_vld_s1 <= 1'b0;
				cfa_pkg::DP_WR_SPLIT: count_q <= count_q + CW'(1);
				cfa_pkg::DP_WR_USED: owner_active_q[id_q] <= 1'b1;
				cfa_pkg::DP_FREE_END: count_q <= count_q - CW'(rm_cnt);
				cfa_pkg::DP_PUSH: out_valid_q <= 1'b1;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			cfa_pkg::DP_LOAD: begin
				type_q <= req_type;
				id_q   <= proc_id;
				size_q <= req_size;
			end
			cfa_pkg::DP_SCAN_START: begin
				src_q       <= '0;
				found_q     <= 1'b0;
				last_free_q <= 1'b0;
				prev_free_q <= 1'b0;
				next_free_q <= 1'b0;
			end
			cfa_pkg::DP_SCAN: begin
				idx_s1 <= src_q[IW-1:0];
				if (re) begin
					src_q <= src_q + CW'(1);
				end
				if (rd_vld_s1) begin
					last_free_q  <= rdata.is_free;
					last_len_q   <= rdata.len;
					last_start_q <= rdata.start;
					if (!type_q) begin
						if (take) begin
							found_q      <= 1'b1;
							pick_idx_q   <= idx_s1;
							pick_len_q   <= rdata.len;
							pick_start_q <= rdata.start;
						end
					end else begin
						if (own_hit) begin
							found_q      <= 1'b1;
							pick_idx_q   <= idx_s1;
							pick_len_q   <= rdata.len;
							pick_start_q <= rdata.start;
							prev_free_q  <= last_free_q;
							prev_len_q   <= last_len_q;
							prev_start_q <= last_start_q;
						end
						// entry right after the released block
						if (found_q && idx_s1 == pick_idx_q + IW'(1)) begin
							next_free_q <= rdata.is_free;
							next_len_q  <= rdata.len;
						end
					end
				end
			end
			cfa_pkg::DP_UP_START: src_q <= count_q - CW'(1);
			cfa_pkg::DP_UP: begin
				idx_s1 <= dst;
				if (re) begin
					src_q <= src_q - CW'(1);
				end
			end
			cfa_pkg::DP_MERGE_WR: src_q <= {1'b0, pick_idx_q} + CW'(1) + CW'(next_free_q);
			cfa_pkg::DP_DOWN: begin
				idx_s1 <= dst;
				if (re) begin
					src_q <= src_q + CW'(1);
				end
			end
			cfa_pkg::DP_PUSH: begin
				status_q      <= cmd.code;
				alloc_start_q <= (cmd.code == cfa_pkg::ST_OK) ? pick_start_q : 12'd0;
			end
			default: begin
			end
		endcase
	end

	assign sts.is_free_req = type_q;
	assign sts.zero_size   = size_q == 13'd0;
	assign sts.id_bad      = 32'(id_q) >= MAX_PROCS;
	assign sts.id_active   = owner_active_q[id_q];
	assign sts.scan_done   = !rd_vld_s1 && !(src_q < count_q);
	assign sts.up_done     = !rd_vld_s1 && !(src_q > {1'b0, pick_idx_q});
	assign sts.found       = found_q;
	assign sts.need_split  = pick_len_q > size_q;
	assign sts.table_full  = count_q >= CW'(MAX_BLOCKS);
	assign sts.out_free    = !out_valid_q || out_ready;

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign alloc_start = alloc_start_q;

endmodule

>>> rtl/cfa_ctrl.sv
// Allocator controller: sequences checks, table scan, shifts and result beat.
`timescale 1ns / 1ps
module cfa_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             cfg_valid,
	input  logic             cfg_index,
	output logic             cfg_ready,
	input  cfa_pkg::dp_sts_t sts,
	output cfa_pkg::dp_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_DECIDE,
		S_UP,
		S_WR_SPLIT,
		S_WR_USED,
		S_DOWN,
		S_FREE_END,
		S_OUT
	} state_t;

	state_t     state_q;
	logic [2:0] code_q;
	logic       chk_err;
	logic [2:0] chk_code;

	always_comb begin
		chk_err  = 1'b1;
		chk_code = cfa_pkg::ST_OK;
		if (sts.is_free_req) begin
			if (sts.id_bad || !sts.id_active) chk_code = cfa_pkg::ST_NOTALLOC;
			else chk_err = 1'b0;
		end else begin
			priority if (sts.zero_size) chk_code = cfa_pkg::ST_ZERO;
			else if (sts.id_bad) chk_code = cfa_pkg::ST_FULL;
			else if (sts.id_active) chk_code = cfa_pkg::ST_DUP;
			else chk_err = 1'b0;
		end
	end

	assign cfg_ready = state_q == S_IDLE;
	assign in_ready  = (state_q == S_IDLE) && !cfg_valid;

	always_comb begin
		cmd.op   = cfa_pkg::DP_NOP;
		cmd.code = code_q;
		unique case (state_q)
			S_INIT:     cmd.op = cfa_pkg::DP_INIT;
			S_IDLE:     if (in_valid && !cfg_valid) cmd.op = cfa_pkg::DP_LOAD;
			S_CHECK:    if (!chk_err) cmd.op = cfa_pkg::DP_SCAN_START;
			S_SCAN:     cmd.op = cfa_pkg::DP_SCAN;
			S_DECIDE: begin
				if (sts.found) begin
					if (sts.is_free_req) cmd.op = cfa_pkg::DP_MERGE_WR;
					else if (sts.need_split && !sts.table_full) cmd.op = cfa_pkg::DP_UP_START;
				end
			end
			S_UP:       cmd.op = cfa_pkg::DP_UP;
			S_WR_SPLIT: cmd.op = cfa_pkg::DP_WR_SPLIT;
			S_WR_USED:  cmd.op = cfa_pkg::DP_WR_USED;
			S_DOWN:     cmd.op = cfa_pkg::DP_DOWN;
			S_FREE_END: cmd.op = cfa_pkg::DP_FREE_END;
			S_OUT:      if (sts.out_free) cmd.op = cfa_pkg::DP_PUSH;
			default:    cmd.op = cfa_pkg::DP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			code_q  <= cfa_pkg::ST_OK;
		end else begin
			unique case (state_q)
				S_INIT: state_q <= S_IDLE;
				S_IDLE: begin
					if (cfg_valid) begin
						// a size write rebuilds the table around entry zero
						if (cfg_index == cfa_pkg::CFG_TOTAL_UNITS) state_q <= S_INIT;
					end else if (in_valid) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (chk_err) begin
						code_q  <= chk_code;
						state_q <= S_OUT;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: if (sts.scan_done) state_q <= S_DECIDE;
				S_DECIDE: begin
					if (sts.is_free_req) begin
						if (sts.found) begin
							state_q <= S_DOWN;
						end else begin
							code_q  <= cfa_pkg::ST_NOTALLOC;
							state_q <= S_OUT;
						end
					end else if (!sts.found) begin
						code_q  <= cfa_pkg::ST_NOFIT;
						state_q <= S_OUT;
					end else if (sts.need_split && sts.table_full) begin
						code_q  <= cfa_pkg::ST_FULL;
						state_q <= S_OUT;
					end else if (sts.need_split) begin
						state_q <= S_UP;
					end else begin
						state_q <= S_WR_USED;
					end
				end
				S_UP: if (sts.up_done) state_q <= S_WR_SPLIT;
				S_WR_SPLIT: state_q <= S_WR_USED;
				S_WR_USED: begin
					code_q  <= cfa_pkg::ST_OK;
					state_q <= S_OUT;
				end
				S_DOWN: if (sts.scan_done) state_q <= S_FREE_END;
				S_FREE_END: begin
					code_q  <= cfa_pkg::ST_OK;
					state_q <= S_OUT;
				end
				S_OUT: if (sts.out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the contiguous fit allocator.
`timescale 1ns / 1ps
module testbench;

	localparam int NBLK = 64;
	localparam int NPROC = 64;
	localparam int MEMU = 4096;
	localparam longint CYCLE_LIMIT = 3000000;

	typedef struct packed {
		logic [2:0]  status;
		logic [11:0] start;
	} alloc_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        req_type = 1'b0;
	logic [5:0]  proc_id = '0;
	logic [12:0] req_size = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  status;
	logic [11:0] alloc_start;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [12:0] cfg_data = '0;

	contiguous_fit_allocator DUT (.*);

	always #10 clk = ~clk;

	// allocator shadow state
	logic [1:0]  pol;
	int          mem_units;
	int          tbl_start [NBLK];
	int          tbl_len [NBLK];
	int          tbl_owner [NBLK];
	bit          tbl_free [NBLK];
	int          tbl_count;
	int          pid_start [NPROC];
	bit          pid_active [NPROC];

	alloc_result_t pending_results [$];
	int  mismatches = 0;
	int  results_seen = 0;
	int  items_sent = 0;
	int  ok_allocs = 0;
	int  full_hits = 0;
	longint cycles = 0;
	bit  sink_idle_en = 1'b1;
	bit  src_idle_en = 1'b1;
	int  sink_hold = 0;

	function automatic void table_reset();
		for (int i = 0; i < NBLK; i++) begin
			tbl_start[i] = 0; tbl_len[i] = 0; tbl_owner[i] = 0; tbl_free[i] = 0;
		end
		for (int i = 0; i < NPROC; i++) begin
			pid_start[i] = 0; pid_active[i] = 0;
		end
		tbl_len[0] = mem_units;
		tbl_free[0] = 1;
		tbl_count = 1;
	endfunction

	function automatic void move_entry(int dst, int src);
		tbl_start[dst] = tbl_start[src];
		tbl_len[dst] = tbl_len[src];
		tbl_owner[dst] = tbl_owner[src];
		tbl_free[dst] = tbl_free[src];
	endfunction

	function automatic int pick_block(int size);
		int pick;
		pick = tbl_count;
		for (int i = 0; i < tbl_count; i++) begin
			if (!tbl_free[i] || tbl_len[i] < size) continue;
			if (pick == tbl_count) begin
				pick = i;
				if (pol != cfa_pkg::POL_BEST && pol != cfa_pkg::POL_WORST) return pick;
			end else if (pol == cfa_pkg::POL_BEST && tbl_len[i] < tbl_len[pick]) begin
				pick = i;
			end else if (pol == cfa_pkg::POL_WORST && tbl_len[i] > tbl_len[pick]) begin
				pick = i;
			end
		end
		return pick;
	endfunction

	function automatic alloc_result_t predict_request(bit is_free_req, int id, int size);
		alloc_result_t r;
		int k;
		int i;
		r.status = cfa_pkg::ST_OK;
		r.start = '0;
		if (!is_free_req) begin
			if (size == 0) r.status = cfa_pkg::ST_ZERO;
			else if (pid_active[id]) r.status = cfa_pkg::ST_DUP;
			else begin
				k = pick_block(size);
				if (k >= tbl_count) r.status = cfa_pkg::ST_NOFIT;
				else if (tbl_len[k] > size && tbl_count >= NBLK) r.status = cfa_pkg::ST_FULL;
				else begin
					if (tbl_len[k] > size) begin
						for (int j = tbl_count; j > k + 1; j--) move_entry(j, j - 1);
						tbl_start[k+1] = tbl_start[k] + size;
						tbl_len[k+1] = tbl_len[k] - size;
						tbl_owner[k+1] = 0;
						tbl_free[k+1] = 1;
						tbl_count++;
					end
					tbl_len[k] = size;
					tbl_owner[k] = id;
					tbl_free[k] = 0;
					pid_start[id] = tbl_start[k];
					pid_active[id] = 1;
					r.start = tbl_start[k];
				end
			end
		end else begin
			if (!pid_active[id]) r.status = cfa_pkg::ST_NOTALLOC;
			else begin
				pid_active[id] = 0;
				r.status = cfa_pkg::ST_NOTALLOC;
				for (i = 0; i < tbl_count; i++)
					if (!tbl_free[i] && tbl_start[i] == pid_start[id] && tbl_owner[i] == id)
						break;
				if (i < tbl_count) begin
					tbl_free[i] = 1;
					tbl_owner[i] = 0;
					r.status = cfa_pkg::ST_OK;
					r.start = pid_start[id];
					i = 0;
					while (i + 1 < tbl_count) begin
						if (tbl_free[i] && tbl_free[i+1]) begin
							tbl_len[i] += tbl_len[i+1];
							for (int j = i + 1; j + 1 < tbl_count; j++) move_entry(j, j + 1);
							tbl_count--;
						end else begin
							i++;
						end
					end
				end
			end
		end
		if (r.status != cfa_pkg::ST_OK) r.start = '0;
		return r;
	endfunction

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycles,
				pending_results.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	// result sink with random stalls and a commanded hold-off
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				alloc_result_t exp_r;
				results_seen++;
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result beat: status %0d start %0d", status,
							alloc_start);
				end else begin
					exp_r = pending_results.pop_front();
					if (status !== exp_r.status || alloc_start !== exp_r.start) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected status %0d start %0d, got %0d %0d",
								exp_r.status, exp_r.start, status, alloc_start);
					end
				end
			end
			if (sink_hold > 0) begin
				sink_hold <= sink_hold - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= !(sink_idle_en && $urandom_range(99) < 13);
			end
		end
	end

	// valid drops only in idle cycles, so back to back beats see one update per edge
	task automatic send_request(bit t, int id, int size);
		while (src_idle_en && $urandom_range(99) < 13) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= t;
		proc_id <= id[5:0];
		req_size <= size[12:0];
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pending_results = {pending_results, predict_request(t, id, size)};
		if (!t && pending_results[$].status == cfa_pkg::ST_OK) ok_allocs++;
		if (pending_results[$].status == cfa_pkg::ST_FULL) full_hits++;
		items_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, int value);
		int v;
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[12:0];
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == cfa_pkg::CFG_FIT_POLICY) begin
			pol = value[1:0];
		end else begin
			v = value & 16'h1FFF;
			if (v < cfa_pkg::MIN_UNITS) v = cfa_pkg::MIN_UNITS;
			if (v > MEMU) v = MEMU;
			mem_units = v;
			table_reset();
		end
		@(posedge clk);
	endtask

	task automatic test_directed();
		send_request(0, 1, 0);
		send_request(0, 1, 10);
		send_request(0, 1, 5);
		send_request(0, 2, 8191);
		send_request(0, 3, 90);
		send_request(0, 4, 10);
		send_request(1, 1, 0);
		send_request(1, 1, 0);
		send_request(1, 63, 4095);
		send_request(0, 63, 20);
		send_request(1, 4, 0);
		send_request(1, 3, 0);
		send_request(1, 63, 0);
		send_request(0, 0, 100);
		send_request(1, 0, 1);
		write_reg(cfa_pkg::CFG_TOTAL_UNITS, 8191);
		send_request(0, 5, 4096);
		send_request(1, 5, 0);
		write_reg(cfa_pkg::CFG_TOTAL_UNITS, 0);
		send_request(0, 6, 101);
		write_reg(cfa_pkg::CFG_FIT_POLICY, 3);
		send_request(0, 7, 50);
		send_request(0, 8, 50);
	endtask

	// fragment the table with unit blocks so splits hit the entry limit
	task automatic test_table_full();
		write_reg(cfa_pkg::CFG_TOTAL_UNITS, 200);
		for (int id = 0; id < 63; id++) send_request(0, id, 1);
		send_request(0, 63, 1);
		send_request(0, 63, 2);
		for (int id = 0; id < 63; id += 2) send_request(1, id, 0);
		send_request(0, 0, 1);
		send_request(0, 2, 2);
	endtask

	task automatic random_phase(int n, int max_size);
		for (int i = 0; i < n; i++) begin
			int r;
			r = $urandom_range(99);
			if (r < 3) send_request(0, $urandom_range(63), 0);
			else if (r < 6) send_request(0, $urandom_range(63), $urandom_range(8191));
			else if (r < 50)
				send_request(0, $urandom_range(63), $urandom_range(max_size, 1));
			else send_request(1, $urandom_range(63), $urandom);
		end
	endtask

	task automatic test_policies();
		int sizes [4] = '{100, 1000, 4096, 300};
		for (int p = 0; p < 4; p++) begin
			write_reg(cfa_pkg::CFG_FIT_POLICY, p);
			write_reg(cfa_pkg::CFG_TOTAL_UNITS, sizes[p]);
			random_phase(350, sizes[p] / 8 + 2);
		end
	endtask

	task automatic test_backpressure();
		write_reg(cfa_pkg::CFG_FIT_POLICY, cfa_pkg::POL_BEST);
		write_reg(cfa_pkg::CFG_TOTAL_UNITS, 1024);
		sink_hold = 400;
		random_phase(30, 60);
		drain();
		src_idle_en = 0;
		sink_idle_en = 0;
		random_phase(150, 60);
		src_idle_en = 1;
		sink_idle_en = 1;
	endtask

	initial begin
		mem_units = cfa_pkg::MIN_UNITS;
		pol = 2'd0;
		table_reset();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);
		test_directed();
		test_table_full();
		test_policies();
		test_backpressure();
		drain();
		$display("Sent %0d requests, %0d results, %0d allocations granted, %0d table full",
			items_sent, results_seen, ok_allocs, full_hits);
		$display("All fit policies, size extremes, back-pressure and source pauses exercised");
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
